/* hw/rtl/pfr_pkg.sv */
`default_nettype none

package pfr_pkg;

  // Panel geometry and derived store sizes.
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int STORE_BYTES  = PANEL_WIDTH * PANEL_HEIGHT / 8;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  // Wide enough for x + PANEL_WIDTH * (y / 8) with any 8-bit x and y.
  localparam int FULL_IDX_W   = 17;

  // Command prefix sent ahead of every frame.
  localparam int       CMD_BYTES  = 3;
  localparam logic [7:0] CMD_COL_LO = 8'h00 | 8'h0;
  localparam logic [7:0] CMD_COL_HI = 8'h10 | 8'h0;
  localparam logic [7:0] CMD_START  = 8'h40 | 8'h0;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_SET  = 3'd0,
    ACT_CLR  = 3'd1,
    ACT_READ = 3'd2,
    ACT_WIPE = 3'd3,
    ACT_TICK = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_t;

  // Classified operation handed from front to back.
  typedef enum logic [2:0] {
    OP_IGNORE,   // unknown action, never busy
    OP_SET,
    OP_CLR,
    OP_READ,
    OP_WIPE,
    OP_TICK,
    OP_RANGE,    // pixel action with a coordinate out of range
    OP_NOIDX     // pixel action whose byte index falls past the store
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RMW
  } bk_state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] x;
    logic [7:0] y;
  } pfr_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       pixel_value;
    logic       link_valid;
    logic [7:0] link_byte;
    logic       link_is_data;
    logic       frame_last;
  } pfr_res_t;

  typedef struct packed {
    op_t              op;
    logic [ADDR_W-1:0] addr;
    logic [2:0]       bit_sel;
  } pfr_cmd_t;

  function automatic logic [7:0] cmd_byte(input logic [ADDR_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      ADDR_W'(0): b = CMD_COL_LO;
      ADDR_W'(1): b = CMD_COL_HI;
      ADDR_W'(2): b = CMD_START;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfr_front.sv */
`default_nettype none

module pfr_front
  import pfr_pkg::*;
(
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pfr_req_t in_req,
  input  wire logic     q_full,
  input  wire logic     back_clearing,
  output logic          q_push,
  output pfr_cmd_t      q_cmd
);

  logic [FULL_IDX_W-1:0] full_idx;
  logic                  x_ok;
  logic                  y_ok;
  logic                  idx_ok;
  logic                  pixel_op;

  assign in_stall = q_full || back_clearing;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    full_idx = FULL_IDX_W'(in_req.y >> 3) * FULL_IDX_W'(PANEL_WIDTH)
             + FULL_IDX_W'(in_req.x);
    x_ok     = {1'b0, in_req.x} < 9'(PANEL_WIDTH);
    y_ok     = {1'b0, in_req.y} < 9'(PANEL_HEIGHT);
    idx_ok   = full_idx < FULL_IDX_W'(STORE_BYTES);
    pixel_op = 1'b0;

    q_cmd.addr    = full_idx[ADDR_W-1:0];
    q_cmd.bit_sel = in_req.y[2:0];
    q_cmd.op      = OP_IGNORE;

    case (in_req.action)
      ACT_SET: begin
        q_cmd.op = OP_SET;
        pixel_op = 1'b1;
      end
      ACT_CLR: begin
        q_cmd.op = OP_CLR;
        pixel_op = 1'b1;
      end
      ACT_READ: begin
        q_cmd.op = OP_READ;
        pixel_op = 1'b1;
      end
      ACT_WIPE: q_cmd.op = OP_WIPE;
      ACT_TICK: q_cmd.op = OP_TICK;
      default:  q_cmd.op = OP_IGNORE;
    endcase

    if (pixel_op) begin
      if (!x_ok || !y_ok) begin
        q_cmd.op = OP_RANGE;
      end else if (!idx_ok) begin
        q_cmd.op = OP_NOIDX;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pfr_queue.sv */
`default_nettype none

module pfr_queue
  import pfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire pfr_cmd_t push_cmd,
  input  wire logic     pop,
  output logic          full,
  output logic          q_valid,
  output pfr_cmd_t      head_cmd
);

  pfr_cmd_t            entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_nxt;

  assign full     = count_r == QCNT_W'(QUEUE_DEPTH);
  assign q_valid  = count_r != '0;
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pfr_back.sv */
`default_nettype none

module pfr_back
  import pfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire pfr_cmd_t q_cmd,
  output logic          q_pop,
  output logic          clearing,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pfr_res_t      out_res
);

  logic [7:0]        mem [STORE_BYTES];

  bk_state_t         state_r;
  bk_state_t         state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_addr_nxt;
  phase_t            phase_r;
  phase_t            phase_nxt;
  logic [ADDR_W-1:0] pos_r;
  logic [ADDR_W-1:0] pos_nxt;
  pfr_cmd_t          cmd_r;
  pfr_cmd_t          cmd_nxt;
  logic [7:0]        rd_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  pfr_res_t          out_res_r;

  logic              slot_free;
  logic              take;
  logic              busy;
  logic              go_rmw;
  logic              go_wipe;
  logic              clr_last;
  logic              emit;
  pfr_res_t          res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mask;
  logic [ADDR_W-1:0] cmd_pos;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign clearing  = state_r == BK_CLEAR;

  // A new command is taken only when the result register can take its answer.
  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    take      = (state_r == BK_IDLE) && q_valid && slot_free;
    busy      = phase_r != PH_IDLE;
    clr_last  = clr_addr_r == ADDR_W'(STORE_BYTES - 1);
    go_rmw    = 1'b0;
    go_wipe   = 1'b0;
    case (q_cmd.op)
      OP_SET, OP_CLR, OP_READ: go_rmw = !busy;
      OP_TICK:                 go_rmw = phase_r == PH_DATA;
      OP_WIPE:                 go_wipe = !busy;
      default:                 go_rmw = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_last) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (take && go_rmw) begin
          state_nxt = BK_RMW;
        end else if (take && go_wipe) begin
          state_nxt = BK_CLEAR;
        end
      end
      BK_RMW:  state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    emit         = 1'b0;
    res          = '0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    clr_addr_nxt = clr_addr_r;
    cmd_nxt      = cmd_r;
    mask         = 8'(1) << cmd_r.bit_sel;
    cmd_pos      = (phase_r == PH_IDLE) ? '0 : pos_r;

    case (state_r)
      BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_last ? '0 : clr_addr_r + 1'b1;
      end
      BK_IDLE: begin
        if (take) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (go_rmw) begin
            mem_re    = 1'b1;
            mem_raddr = (q_cmd.op == OP_TICK) ? pos_r : q_cmd.addr;
          end else begin
            emit = 1'b1;
            case (q_cmd.op)
              OP_TICK: begin
                // Command prefix byte; a tick from idle starts a new frame.
                res.link_valid = 1'b1;
                res.link_byte  = cmd_byte(cmd_pos);
                if (cmd_pos == ADDR_W'(CMD_BYTES - 1)) begin
                  phase_nxt = PH_DATA;
                  pos_nxt   = '0;
                end else begin
                  phase_nxt = PH_CMD;
                  pos_nxt   = cmd_pos + 1'b1;
                end
              end
              OP_IGNORE: res.status = ST_OK;
              OP_RANGE:  res.status = busy ? ST_BUSY : ST_RANGE;
              default:   res.status = busy ? ST_BUSY : ST_OK;
            endcase
          end
        end
      end
      BK_RMW: begin
        emit = 1'b1;
        case (cmd_r.op)
          OP_SET: begin
            mem_we    = 1'b1;
            mem_waddr = cmd_r.addr;
            mem_wdata = rd_data_r | mask;
          end
          OP_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = cmd_r.addr;
            mem_wdata = rd_data_r & ~mask;
          end
          OP_READ: res.pixel_value = (rd_data_r & mask) != 8'h00;
          OP_TICK: begin
            res.link_valid   = 1'b1;
            res.link_byte    = rd_data_r;
            res.link_is_data = 1'b1;
            if (pos_r == ADDR_W'(STORE_BYTES - 1)) begin
              res.frame_last = 1'b1;
              phase_nxt      = PH_IDLE;
              pos_nxt        = '0;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end
          default: res = '0;
        endcase
      end
      default: emit = 1'b0;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (emit) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/page_framebuffer_refresh.sv */
`default_nettype none

// Channel  Direction  Handshake           Payload
// in_      request    in_valid/in_stall   in_req  (pfr_req_t: action, x, y)
// out_     result     out_valid/out_stall out_res (pfr_res_t: status, pixel, link fields)
//
// One result leaves for every request, in request order.
// Set, clear and read pixel and a refresh tick in the data phase pass through
// the back end as a store read, then a write or answer; refresh command bytes
// and requests answered by status alone are answered straight from idle.
// Clear store answers at once and, outside a refresh, sweeps the 1024-byte
// store one byte a cycle; the same sweep runs after reset, and in_stall is
// high while it runs. in_stall is also high while the two-entry queue is full.
// While a result waits under out_stall, the front keeps taking requests until
// the queue is full.

module page_framebuffer_refresh
  import pfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pfr_req_t in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pfr_res_t      out_res
);

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_valid;
  logic     back_clearing;
  pfr_cmd_t push_cmd;
  pfr_cmd_t head_cmd;

  // The front decodes the action, checks the coordinates and computes the
  // page-layout byte index and bit; it keeps no state of the frame.
  pfr_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .q_full        (q_full),
    .back_clearing (back_clearing),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // A short queue lets the front keep taking requests while the back end
  // waits on a stalled result.
  pfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head_cmd (head_cmd)
  );

  // The back end owns the frame store, the refresh phase and the stream
  // position, so busy is judged in request order against the true phase.
  pfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .clearing  (back_clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire
